// File: hdl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; include guard keeps a second include harmless
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DSNS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define DSNS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/dsns_pkg.sv
// package for the decaying sine note synth: beat types, command codes,
// default parameters and elaboration-time table functions; no dependencies
package dsns_pkg;

  // default parameter values
  localparam int unsigned DSNS_SAMPLE_RATE     = 44100;
  localparam int unsigned DSNS_QUARTER_SAMPLES = 7938;
  localparam int unsigned DSNS_MAX_BEATS       = 8;
  localparam int unsigned DSNS_SINE_ADDR_BITS  = 10;

  // command codes
  localparam logic CmdNoteOn = 1'b0;
  localparam logic CmdTick   = 1'b1;

  // fixed-point constants
  localparam logic [31:0] OneQ30    = 32'h4000_0000;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // input beat
  typedef struct packed {
    logic       cmd;
    logic [6:0] pitch;
    logic [3:0] beats;
  } dsns_in_t;

  // output beat
  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } dsns_out_t;

  // 2^(k/12) in Q16
  typedef logic [31:0] semi_tab_t [12];
  localparam semi_tab_t SemitoneQ16 = '{
    32'd65536, 32'd69433, 32'd73562, 32'd77936, 32'd82570, 32'd87480,
    32'd92682, 32'd98193, 32'd104032, 32'd110218, 32'd116772, 32'd123715
  };

  // one sine table entry in Q15, quarter-wave symmetric Taylor series computed in Q30
  function automatic logic signed [15:0] dsns_sine_entry(int unsigned addr,
                                                         int unsigned abits);
    int unsigned qbits;
    int unsigned quarter;
    int unsigned quad;
    int unsigned r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    qbits   = abits - 2;
    quarter = 1 << qbits;
    quad    = (addr >> qbits) & 3;
    r       = addr & (quarter - 1);
    if (quad[0]) begin
      r = quarter - r;
    end
    x    = (64'(r) * HalfPiQ30) >> qbits;
    x2   = (x * x) >> 30;
    sum  = x;
    term = ((x * x2) >> 30) / 6;      sum = sum - term;
    term = ((term * x2) >> 30) / 20;  sum = sum + term;
    term = ((term * x2) >> 30) / 42;  sum = sum - term;
    term = ((term * x2) >> 30) / 72;  sum = sum + term;
    term = ((term * x2) >> 30) / 110; sum = sum - term;
    term = ((term * x2) >> 30) / 156; sum = sum + term;
    term = ((term * x2) >> 30) / 210; sum = sum - term;
    if (quad < 2) begin
      mag = sum >> 15;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      return 16'(mag);
    end
    mag = (sum + 64'd32767) >> 15;
    if (mag > 64'd32768) begin
      mag = 64'd32768;
    end
    return 16'(64'd0 - mag);
  endfunction

  // decay factor exp(-y) in Q30 from y in Q30, truncated series to fifth order
  function automatic logic [31:0] dsns_decay(logic [63:0] y);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'(OneQ30);
    sum  = 64'(OneQ30);
    term = (term * y) >> 30;       sum = sum - term;
    term = ((term * y) >> 30) / 2; sum = sum + term;
    term = ((term * y) >> 30) / 3; sum = sum - term;
    term = ((term * y) >> 30) / 4; sum = sum + term;
    term = ((term * y) >> 30) / 5; sum = sum - term;
    return sum[31:0];
  endfunction

endpackage

// File: hdl/dsns_sine_rom.sv
// sine lookup table with registered read, built at elaboration
// depends on dsns_pkg for the entry function
module dsns_sine_rom import dsns_pkg::*; #(
  parameter int unsigned ADDR_BITS = DSNS_SINE_ADDR_BITS
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  output logic signed [15:0]   data_o
);

  localparam int unsigned Depth = 1 << ADDR_BITS;

  typedef logic signed [15:0] sine_tab_t [Depth];

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    for (int unsigned i = 0; i < Depth; i++) begin
      t[i] = dsns_sine_entry(i, ADDR_BITS);
    end
    return t;
  endfunction

  localparam sine_tab_t SineRom = build_sine();

  logic signed [15:0] data_q;

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= SineRom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// File: hdl/decaying_sine_note_synth.sv
// a tick beat's sample is registered in the sine table read register, then in the output register
// throughput: one beat per cycle while the output is not held; note-on beats give no output
// the sine table read register and the output register after the amplitude multiply set the two stages
// reset: phase, step, envelope, decay and sample count clear; no note plays
// and all stage valids drop
module decaying_sine_note_synth import dsns_pkg::*; #(
  parameter int unsigned SAMPLE_RATE     = DSNS_SAMPLE_RATE,
  parameter int unsigned QUARTER_SAMPLES = DSNS_QUARTER_SAMPLES,
  parameter int unsigned MAX_BEATS       = DSNS_MAX_BEATS,
  parameter int unsigned SINE_ADDR_BITS  = DSNS_SINE_ADDR_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dsns_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dsns_out_t out_data_o
);

  // phase increment per pitch
  typedef logic [31:0] step_tab_t [128];

  function automatic step_tab_t build_steps();
    step_tab_t   t;
    int unsigned idx;
    int unsigned k;
    int unsigned sh;
    logic [63:0] num;
    for (int unsigned p = 0; p < 128; p++) begin
      idx  = p + 3;
      k    = idx % 12;
      sh   = idx / 12 + 10;
      num  = (64'd440 * 64'(SemitoneQ16[k])) << sh;
      t[p] = 32'((num + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));
    end
    return t;
  endfunction

  localparam step_tab_t StepTab = build_steps();

  // decay factor per note length in quarter beats
  typedef logic [63:0] y_tab_t [8];
  localparam y_tab_t DecayY = '{
    ((64'd1 << 31) + 64'(QUARTER_SAMPLES * 1) / 2) / 64'(QUARTER_SAMPLES * 1),
    ((64'd1 << 31) + 64'(QUARTER_SAMPLES * 2) / 2) / 64'(QUARTER_SAMPLES * 2),
    ((64'd1 << 31) + 64'(QUARTER_SAMPLES * 3) / 2) / 64'(QUARTER_SAMPLES * 3),
    ((64'd1 << 31) + 64'(QUARTER_SAMPLES * 4) / 2) / 64'(QUARTER_SAMPLES * 4),
    ((64'd1 << 31) + 64'(QUARTER_SAMPLES * 5) / 2) / 64'(QUARTER_SAMPLES * 5),
    ((64'd1 << 31) + 64'(QUARTER_SAMPLES * 6) / 2) / 64'(QUARTER_SAMPLES * 6),
    ((64'd1 << 31) + 64'(QUARTER_SAMPLES * 7) / 2) / 64'(QUARTER_SAMPLES * 7),
    ((64'd1 << 31) + 64'(QUARTER_SAMPLES * 8) / 2) / 64'(QUARTER_SAMPLES * 8)
  };

  typedef logic [31:0] decay_tab_t [8];
  localparam decay_tab_t DecayTab = '{
    dsns_decay(DecayY[0]), dsns_decay(DecayY[1]), dsns_decay(DecayY[2]),
    dsns_decay(DecayY[3]), dsns_decay(DecayY[4]), dsns_decay(DecayY[5]),
    dsns_decay(DecayY[6]), dsns_decay(DecayY[7])
  };

  localparam logic [3:0]  MaxBeats = 4'(MAX_BEATS);
  localparam logic [15:0] QuarterW = 16'(QUARTER_SAMPLES);

  // voice state
  logic [31:0] phase_q, phase_d;
  logic [31:0] step_q, step_d;
  logic [31:0] env_q, env_d;
  logic [31:0] decay_q, decay_d;
  logic [15:0] left_q, left_d;

  // stage one: table read and captured envelope
  logic        s1_valid_q, s1_valid_d;
  logic        s1_play_q;
  logic        s1_last_q;
  logic [31:0] s1_env_q;
  logic signed [15:0] rom_data;

  // stage two: output register
  logic      out_valid_q, out_valid_d;
  dsns_out_t out_q, out_d;

  logic        in_fire;
  logic        is_tick;
  logic        playing;
  logic        out_free;
  logic        s1_adv;
  logic [3:0]  beats_c;
  logic [2:0]  beats_idx;
  logic [63:0] env_prod;
  logic [16:0] rom_mag;
  logic [48:0] amp_prod;
  logic [18:0] amp_mag;

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_tick    = (in_data_i.cmd == CmdTick);
  assign playing    = (left_q != 16'd0);

  // note length clamp to the supported range
  always_comb begin
    priority if (in_data_i.beats == 4'd0) begin
      beats_c = 4'd1;
    end else if (in_data_i.beats > MaxBeats) begin
      beats_c = MaxBeats;
    end else begin
      beats_c = in_data_i.beats;
    end
  end
  assign beats_idx = 3'(beats_c - 4'd1);

  assign env_prod = 64'(env_q) * 64'(decay_q);

  // voice state update on an accepted note-on, or on an accepted tick while a note plays
  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    env_d   = env_q;
    decay_d = decay_q;
    left_d  = left_q;
    if (in_fire) begin
      if (!is_tick) begin
        phase_d = '0;
        step_d  = StepTab[in_data_i.pitch];
        env_d   = OneQ30;
        decay_d = DecayTab[beats_idx];
        left_d  = 16'(20'(beats_c) * 20'(QuarterW));
      end else if (playing) begin
        phase_d = phase_q + step_q;
        env_d   = env_prod[61:30];
        left_d  = left_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      env_q   <= '0;
      decay_q <= '0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      env_q   <= env_d;
      decay_q <= decay_d;
      left_q  <= left_d;
    end
  end

  // sine table addressed by the top phase bits
  dsns_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine_rom (
    .clk_i   (clk_i),
    .rd_en_i (in_fire && is_tick),
    .addr_i  (phase_q[31 -: SINE_ADDR_BITS]),
    .data_o  (rom_data)
  );

  // stage one valid
  always_comb begin
    priority if (in_fire && is_tick) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (in_fire && is_tick) begin
      s1_play_q <= playing;
      s1_last_q <= (left_q == 16'd1);
      s1_env_q  <= env_q;
    end
  end

  // amplitude scaling, sign applied after truncation
  assign rom_mag  = rom_data[15] ? 17'(-18'(rom_data)) : 17'(rom_data);
  assign amp_prod = 49'(rom_mag) * 49'(s1_env_q);
  assign amp_mag  = amp_prod[48:30];

  always_comb begin
    out_d = out_q;
    if (s1_adv) begin
      out_d.last = s1_play_q && s1_last_q;
      priority if (!s1_play_q) begin
        out_d.sample = '0;
      end else if (rom_data[15]) begin
        out_d.sample = 16'(~amp_mag[15:0] + 16'd1);
      end else begin
        out_d.sample = amp_mag[15:0];
      end
    end
  end

  always_comb begin
    priority if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/dsns_checker.sv
// port-level checker for the decaying sine note synth, bound to the top level
// depends on dsns_pkg and assert_macros.svh
`include "assert_macros.svh"

module dsns_checker import dsns_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input dsns_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input dsns_out_t out_data_o
);

  // a held output beat stays valid
  `DSNS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // a held output beat keeps its payload
  `DSNS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))

  // input stalls only behind a waiting output beat
  `DSNS_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // a note-on adds nothing to the pipe, so the next beat is taken
  `DSNS_ASSERT_NEXT(a_note_on_ready, clk_i, rst_ni, in_valid_i && in_ready_o && (in_data_i.cmd == CmdNoteOn), in_ready_o)

endmodule

bind decaying_sine_note_synth dsns_checker u_dsns_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
